// ----- hdl/xtea_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// XTEA cipher package
// Shared widths, register indexes and round helpers for the XTEA pipeline.
// ============================================================================
package xtea_pkg;

    localparam int WORD_W      = 32;
    localparam int ROUND_COUNT = 32;
    localparam int HALF_COUNT  = 2 * ROUND_COUNT;
    localparam int KEY_WORDS   = 4;
    localparam int KEY_IDX_W   = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int NBYTES_W    = 4;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 64;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 8'd3;

    // Direction codes carried in tuser.
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Round sum after n additions of the constant, modulo 2^32.
    function automatic logic [WORD_W-1:0] round_sum(input int n);
        logic [2*WORD_W-1:0] prod;
        prod = {{WORD_W{1'b0}}, DELTA} * (2*WORD_W)'(n);
        return prod[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

// ----- hdl/xtea_block_cipher.sv -----
`timescale 1ns / 1ps
// ============================================================================
// XTEA block cipher
// Fully unrolled 32-round XTEA pipeline with a two-item output buffer.
// ============================================================================
// The block accepts one 64-bit item per clock and returns it encrypted or
// decrypted under the 128-bit key held in four configuration registers. Each
// item passes first through one input stage that applies the partial
// block zero padding, then one stage per half-round (64 in all), each stage
// holding one subtract-or-add of the mixed word. After the last stage the
// item lands in a two-entry output buffer, so input items keep flowing while
// a finished result waits to be taken; the pipeline holds only while that
// buffer is full. The key words feed a row of per-stage key terms that are
// refreshed every cycle, so a key write takes effect for items accepted from
// the cycle after the write. The configuration port is always ready.
module xtea_block_cipher
    import xtea_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Input items.
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata fields, lowest bit up: block_lo[31:0], block_hi[63:32],
    // valid_bytes[67:64], zero fill[71:68].
    input  logic [IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser fields: op[0] (0 encrypt, 1 decrypt).
    input  logic                     s_axis_tuser,
    // Result items.
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata fields, lowest bit up: result_lo[31:0], result_hi[63:32].
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
    // Configuration write channel.
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [WORD_W-1:0]        cfg_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // Key registers.
    logic [WORD_W-1:0] key_reg [KEY_WORDS];

    // Pipeline stage registers; stage 0 is the input stage.
    logic              vld_reg [HALF_COUNT+1];
    logic              op_reg  [HALF_COUNT+1];
    logic [WORD_W-1:0] y_reg   [HALF_COUNT+1];
    logic [WORD_W-1:0] z_reg   [HALF_COUNT+1];

    // Output buffer.
    logic [OUT_TDATA_W-1:0] fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic advance;
    logic push;
    logic pop;

    // Input field extraction.
    logic [WORD_W-1:0]      in_lo;
    logic [WORD_W-1:0]      in_hi;
    logic [NBYTES_W-1:0]    in_nbytes;
    logic [2*WORD_W-1:0]    keep_mask;
    logic [2*WORD_W-1:0]    in_block;

    assign in_lo     = s_axis_tdata[WORD_W-1:0];
    assign in_hi     = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign in_nbytes = s_axis_tdata[2*WORD_W+NBYTES_W-1:2*WORD_W];

    // The whole pipeline moves together unless the output buffer is full.
    assign advance       = (count_reg != CNT_W'(FIFO_DEPTH));
    assign s_axis_tready = advance;
    assign cfg_ready     = 1'b1;

    // Partial block zero padding: bytes at and above valid_bytes are cleared
    // on encrypt. Out-of-range counts use the whole block.
    always_comb
    begin
        unique case (in_nbytes)
            4'd1:    keep_mask = 64'h0000_0000_0000_00FF;
            4'd2:    keep_mask = 64'h0000_0000_0000_FFFF;
            4'd3:    keep_mask = 64'h0000_0000_00FF_FFFF;
            4'd4:    keep_mask = 64'h0000_0000_FFFF_FFFF;
            4'd5:    keep_mask = 64'h0000_00FF_FFFF_FFFF;
            4'd6:    keep_mask = 64'h0000_FFFF_FFFF_FFFF;
            4'd7:    keep_mask = 64'h00FF_FFFF_FFFF_FFFF;
            default: keep_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        if (s_axis_tuser == OP_ENCRYPT)
        begin
            in_block = {in_hi, in_lo} & keep_mask;
        end
        else
        begin
            in_block = {in_hi, in_lo};
        end
    end

    // Key register writes; indexes beyond the key words are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_WORD0: key_reg[0] <= cfg_data;
                REG_KEY_WORD1: key_reg[1] <= cfg_data;
                REG_KEY_WORD2: key_reg[2] <= cfg_data;
                REG_KEY_WORD3: key_reg[3] <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op_reg[0] <= s_axis_tuser;
            y_reg[0]  <= in_block[WORD_W-1:0];
            z_reg[0]  <= in_block[2*WORD_W-1:WORD_W];
        end
    end

    // One stage per half-round. Encrypt runs the half-rounds forward and
    // decrypt runs them backward, so each stage holds both key terms and
    // picks one by the item's direction.
    for (genvar h = 0; h < HALF_COUNT; h++)
    begin : g_stage
        localparam int  RND = h / 2;
        localparam bit  ODD = (h % 2) == 1;
        localparam logic [WORD_W-1:0] ENC_SUM =
            ODD ? round_sum(RND + 1) : round_sum(RND);
        localparam logic [WORD_W-1:0] DEC_SUM =
            ODD ? round_sum(ROUND_COUNT - RND - 1) : round_sum(ROUND_COUNT - RND);
        localparam logic [KEY_IDX_W-1:0] ENC_IDX =
            ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
        localparam logic [KEY_IDX_W-1:0] DEC_IDX =
            ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

        logic [WORD_W-1:0] ekt_reg;
        logic [WORD_W-1:0] dkt_reg;
        logic              upd_y;
        logic [WORD_W-1:0] src;
        logic [WORD_W-1:0] dst;
        logic [WORD_W-1:0] term;
        logic [WORD_W-1:0] dst_next;

        always_ff @(posedge clk)
        begin
            ekt_reg <= ENC_SUM + key_reg[ENC_IDX];
            dkt_reg <= DEC_SUM + key_reg[DEC_IDX];
        end

        always_comb
        begin
            // Encrypt first halves and decrypt second halves update y.
            upd_y = (op_reg[h] == OP_DECRYPT) == ODD;
            src   = upd_y ? z_reg[h] : y_reg[h];
            dst   = upd_y ? y_reg[h] : z_reg[h];
            term  = mix_word(src) ^ ((op_reg[h] == OP_DECRYPT) ? dkt_reg : ekt_reg);
            if (op_reg[h] == OP_DECRYPT)
            begin
                dst_next = dst - term;
            end
            else
            begin
                dst_next = dst + term;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[h+1] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[h+1] <= vld_reg[h];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                op_reg[h+1] <= op_reg[h];
                y_reg[h+1]  <= upd_y ? dst_next : y_reg[h];
                z_reg[h+1]  <= upd_y ? z_reg[h] : dst_next;
            end
        end
    end

    // Output buffer.
    assign push = advance && vld_reg[HALF_COUNT];
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= {z_reg[HALF_COUNT], y_reg[HALF_COUNT]};
        end
    end

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = fifo_reg[rd_ptr_reg];

endmodule

// ----- hdl/xtea_block_cipher_check.sv -----
`timescale 1ns / 1ps
// ============================================================================
// XTEA block cipher port checker
// Port-level assertions on the cipher, attached to the top level by bind.
// ============================================================================
module xtea_block_cipher_check
    import xtea_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A result item that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its data.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // With no result waiting, the output buffer has room, so input flows.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Input backpressure only follows a result item that was held back.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

bind xtea_block_cipher xtea_block_cipher_check u_check (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// XTEA block cipher testbench
// Streams blocks through the cipher pipeline under several keys and handshake
// patterns, and checks each returned block against a local cipher model.
// ============================================================================
// The stimulus starts with a directed set at the reset key: zero and all-ones
// blocks in both directions, every value of the byte count on encrypt (the
// out-of-range counts included), and partial counts on decrypt, which must be
// ignored. Random phases follow, each under a new key: all ones, a counting
// pattern, zero written back explicitly, and random keys. Writes to unknown
// register indexes are mixed in and must leave the key alone. Every phase
// uses one of four idle patterns on the two stream sides. One phase holds the
// result side off for a long stretch so that the pipeline fills and stalls
// its input, and another pauses the sender until every block has come back.
// About half of the random decrypt items replay the latest predicted cipher
// text, so decryption is also exercised on meaningful data.
module testbench;
    import xtea_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
    } block_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the key, predicts the block for each
    // accepted item and checks the returned items in order.
    // ------------------------------------------------------------------------
    class cipher_scoreboard;
        logic [WORD_W-1:0] key[KEY_WORDS];
        block_t            awaited_blocks[$];
        block_t            last_cipher;
        int                mismatches;

        function new();
            foreach (key[i])
                key[i] = '0;
            last_cipher = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                REG_KEY_WORD0: key[0] = data;
                REG_KEY_WORD1: key[1] = data;
                REG_KEY_WORD2: key[2] = data;
                REG_KEY_WORD3: key[3] = data;
                default: ;
            endcase
        endfunction

        function logic [WORD_W-1:0] diffuse(logic [WORD_W-1:0] v);
            return ((v << 4) ^ (v >> 5)) + v;
        endfunction

        function block_t encipher(block_t blk);
            logic [WORD_W-1:0] y;
            logic [WORD_W-1:0] z;
            logic [WORD_W-1:0] s;
            y = blk.lo;
            z = blk.hi;
            s = '0;
            for (int r = 0; r < ROUND_COUNT; r++)
            begin
                y = y + (diffuse(z) ^ (s + key[s[1:0]]));
                s = s + DELTA;
                z = z + (diffuse(y) ^ (s + key[s[12:11]]));
            end
            return {z, y};
        endfunction

        function block_t decipher(block_t blk);
            logic [WORD_W-1:0] y;
            logic [WORD_W-1:0] z;
            logic [WORD_W-1:0] s;
            y = blk.lo;
            z = blk.hi;
            s = DELTA * WORD_W'(ROUND_COUNT);
            for (int r = 0; r < ROUND_COUNT; r++)
            begin
                z = z - (diffuse(y) ^ (s + key[s[12:11]]));
                s = s - DELTA;
                y = y - (diffuse(z) ^ (s + key[s[1:0]]));
            end
            return {z, y};
        endfunction

        // Called for every accepted input item.
        function void note_block(logic op, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                                 logic [NBYTES_W-1:0] nbytes);
            logic [2*WORD_W-1:0] whole;
            int unsigned         used;
            block_t              out;
            whole = {hi, lo};
            // Counts of zero or above eight mean a full block.
            used = (nbytes == 0 || nbytes > 8) ? 8 : nbytes;
            if (op == OP_ENCRYPT)
            begin
                if (used < 8)
                    whole = whole & ((64'd1 << (8 * used)) - 64'd1);
                out = encipher(whole);
                last_cipher = out;
            end
            else
            begin
                out = decipher(whole);
            end
            awaited_blocks.push_back(out);
        endfunction

        // Called for every accepted result item.
        function void check_block(logic [OUT_TDATA_W-1:0] tdata);
            block_t want;
            block_t got;
            got = tdata;
            if (awaited_blocks.size() == 0)
            begin
                $error("result item with none expected: %h", tdata);
                mismatches++;
                return;
            end
            want = awaited_blocks.pop_front();
            if (got.lo !== want.lo)
            begin
                $error("result_lo mismatch: expected %h, actual %h", want.lo, got.lo);
                mismatches++;
            end
            if (got.hi !== want.hi)
            begin
                $error("result_hi mismatch: expected %h, actual %h", want.hi, got.hi);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited_blocks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, clock and the block itself.
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata fields, lowest bit up: block_lo, block_hi, valid_bytes, zero fill.
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser fields: op.
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata fields, lowest bit up: result_lo, result_hi.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data = '0;

    // Percent of cycles in which each side idles, and the long hold flag.
    int unsigned            send_idle_pct = 0;
    int unsigned            recv_stall_pct = 0;
    logic                   recv_hold = 1'b0;

    cipher_scoreboard       sb = new();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xtea_block_cipher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: checks each accepted item, then picks the ready level for
    // the next cycle. The values sampled here are those from before the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_block(m_axis_tdata);
        if (!rst_n || recv_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task starts and ends just after a rising edge. The input
    // valid is left high after an item so that back-to-back items need only
    // one assignment per edge; idle cycles and the drain lower it.
    // ------------------------------------------------------------------------
    task automatic send_block(logic op, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                              logic [NBYTES_W-1:0] nbytes);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, nbytes, hi, lo};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_block(op, lo, hi, nbytes);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_key(logic [WORD_W-1:0] k0, logic [WORD_W-1:0] k1,
                            logic [WORD_W-1:0] k2, logic [WORD_W-1:0] k3);
        cfg_write(REG_KEY_WORD0, k0);
        cfg_write(REG_KEY_WORD1, k1);
        cfg_write(REG_KEY_WORD2, k2);
        cfg_write(REG_KEY_WORD3, k3);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering items and waits until every block has come back, so the block is truly idle.
    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0 && guard < 50_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (HALF_COUNT + 8) @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return WORD_W'(1) << $urandom_range(WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic                op;
        logic [WORD_W-1:0]   lo;
        logic [WORD_W-1:0]   hi;
        logic [NBYTES_W-1:0] nbytes;
        op = $urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT;
        lo = rand_word();
        hi = rand_word();
        // Replaying the latest cipher text makes decryption return plain text.
        if (op == OP_DECRYPT && $urandom_range(1))
        begin
            lo = sb.last_cipher.lo;
            hi = sb.last_cipher.hi;
        end
        nbytes = ($urandom_range(3) == 0) ? NBYTES_W'($urandom_range(15)) : NBYTES_W'(8);
        send_block(op, lo, hi, nbytes);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed items at the reset key, no idling on either side.
        send_block(OP_ENCRYPT, '0, '0, 4'd8);
        send_block(OP_DECRYPT, '0, '0, 4'd8);
        send_block(OP_ENCRYPT, '1, '1, 4'd8);
        send_block(OP_DECRYPT, '1, '1, 4'd8);
        // Every byte count on encrypt; zero and nine up must act as eight.
        for (int n = 0; n < 16; n++)
            send_block(OP_ENCRYPT, '1, '1, NBYTES_W'(n));
        // Partial counts on decrypt leave the block untouched.
        send_block(OP_DECRYPT, 32'h8765_4321, 32'hFEDC_BA98, 4'd3);
        send_block(OP_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF, 4'd0);
        send_block(OP_DECRYPT, sb.last_cipher.lo, sb.last_cipher.hi, 4'd15);
        drain();

        for (int phase = 1; phase <= 6; phase++)
        begin
            case (phase)
                1: load_key('1, '1, '1, '1);
                2:
                begin
                    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
                    // Unknown indexes must not disturb the key.
                    cfg_write(CFG_INDEX_W'(KEY_WORDS), $urandom);
                    cfg_write('1, $urandom);
                    cfg_valid <= 1'b0;
                    @(posedge clk);
                end
                5: load_key('0, '0, '0, '0);
                default: load_key($urandom, $urandom, $urandom, $urandom);
            endcase

            // Idle patterns: none, sender 75%, receiver 75%, both 34%.
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase

            if (phase == 2)
            begin
                // The result side holds off long enough for the pipeline and
                // its output buffer to fill, so the input must stall too.
                fork
                    begin
                        recv_hold <= 1'b1;
                        repeat (400) @(posedge clk);
                        recv_hold <= 1'b0;
                    end
                    begin
                        repeat (240) send_random();
                    end
                join
            end
            else if (phase == 3)
            begin
                // The sender pauses mid-phase until the pipeline is empty.
                repeat (120) send_random();
                drain();
                repeat (120) send_random();
            end
            else
            begin
                repeat (240) send_random();
            end
            drain();
        end

        if (sb.pending() > 0)
        begin
            $error("%0d expected result items never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/xtea_pkg.sv
hdl/xtea_block_cipher.sv
hdl/xtea_block_cipher_check.sv
tb/sv/testbench.sv
